[rtl/ita_pkg.sv]
// Shared types, character codes and helpers for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ita_pkg;

   localparam int VALUE_W     = 32;
   localparam int DEC_DIGITS  = 10;
   localparam int HEX_DIGITS  = VALUE_W / 4;
   localparam int DIGIT_W     = 4;
   localparam int CNT_W       = $clog2(DEC_DIGITS + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [3:0] DEC_RADIX  = 4'd10;

   // One classified number waiting for conversion.
   typedef struct packed {
      logic                 neg;
      logic                 hex;
      logic [VALUE_W-1:0]   mag;
   } entry_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [7:0] wide;
      wide = {4'b0000, d};
      if (d >= DEC_RADIX) begin
         digit_char = wide - {4'b0000, DEC_RADIX} + CH_A;
      end else begin
         digit_char = wide + CH_ZERO;
      end
   endfunction

endpackage

`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: mode register, front end, queue, back end.
// Depends on ita_pkg, ita_front, ita_queue and ita_back.
//
//  channel  direction  beat content
//  req_     in         tdata[31:0] = value (signed)
//  rsp_     out        tdata[7:0] = text_byte, tlast = last
//  csr_     in         tdata[7:0], bit 0 = hex_mode
//
// Decimal: load, double-dabble over all 32 value bits in the back end, leading zero skip,
// then one byte per cycle while rsp_ is not stalled (2 to 12 bytes).
// Hex: load, leading zero skip, then one byte per cycle while rsp_ is not stalled.
// The front end and queue keep accepting numbers while the back end works.
// Reset is synchronous, active high; it clears the mode to decimal and empties the queue.
// A stalled rsp_ beat holds the back end; req_ stalls only when the queue is full.
`default_nettype none

module integer_to_ascii_formatter #(
   parameter int FIFO_DEPTH = ita_pkg::QUEUE_DEPTH
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [31:0]  req_tdata,    // [31:0] value
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [7:0]   rsp_tdata,    // [7:0] text_byte
   output logic         rsp_tlast,
   input  wire          csr_tvalid,
   output logic         csr_tready,
   input  wire  [7:0]   csr_tdata     // [0] hex_mode, upper bits ignored
);
   import ita_pkg::*;

   logic      hex_mode_ff;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop;
   entry_type pop_entry;

   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_mode_ff <= 1'b0;
      end else if (csr_tvalid && csr_tready) begin
         hex_mode_ff <= csr_tdata[0];
      end
   end

   ita_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .hex_mode   (hex_mode_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   ita_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   ita_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/ita_front.sv]
// Front end: accepts input beats, splits sign and magnitude, tags the radix.
// Depends on ita_pkg; feeds ita_queue.
`default_nettype none

module ita_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [31:0]             req_tdata,
   input  wire                     hex_mode,
   output logic                    push_valid,
   input  wire                     push_ready,
   output ita_pkg::entry_type      push_entry
);
   import ita_pkg::*;

   logic      hold_valid_ff, hold_valid_in;
   entry_type entry_ff, entry_in;
   logic      take;
   logic      neg;

   assign neg        = req_tdata[VALUE_W-1];
   assign req_tready = !hold_valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      entry_in      = entry_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         entry_in.neg  = neg;
         entry_in.hex  = hex_mode;
         // two's complement negate; the most negative value maps to 2^31
         entry_in.mag  = neg ? (~req_tdata + 32'd1) : req_tdata;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

[rtl/ita_queue.sv]
// Short queue of classified numbers between front end and back end.
// Depends on ita_pkg for the entry type.
`default_nettype none

module ita_queue #(
   parameter int DEPTH = ita_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   output logic                    push_ready,
   input  ita_pkg::entry_type      push_entry,
   output logic                    pop_valid,
   input  wire                     pop,
   output ita_pkg::entry_type      pop_entry
);
   import ita_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   entry_type          slots [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != COUNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/ita_back.sv]
// Back end: bit-serial binary to BCD conversion, leading zero skip, byte output.
// Depends on ita_pkg; drains ita_queue and drives the result beat register.
`default_nettype none

module ita_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     pop_valid,
   output logic                    pop,
   input  ita_pkg::entry_type      pop_entry,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import ita_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT,
      ST_NEWLINE
   } state_type;

   state_type              state_ff;
   logic                   neg_ff;
   logic [VALUE_W-1:0]     mag_ff;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [DIGIT_W-1:0]     digits_ff [DEC_DIGITS];
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_data_ff;
   logic                   rsp_last_ff;

   logic [DIGIT_W-1:0]     adj [DEC_DIGITS];
   logic [DIGIT_W-1:0]     dab_in [DEC_DIGITS];
   logic [CNT_W-1:0]       top_idx;
   logic [DIGIT_W-1:0]     top_digit;
   logic                   slot_free;
   logic                   emit;

   assign pop        = (state_ff == ST_IDLE) && pop_valid;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit       = slot_free && (state_ff == ST_SIGN || state_ff == ST_DIGIT ||
                                     state_ff == ST_NEWLINE);
   assign top_idx    = cnt_ff - CNT_W'(1);
   assign top_digit  = digits_ff[top_idx];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // One double-dabble step: add 3 to digits of 5 or more, then shift in the next bit.
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      dab_in[0] = {adj[0][DIGIT_W-2:0], mag_ff[VALUE_W-1]};
      for (int i = 1; i < DEC_DIGITS; i++) begin
         dab_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  neg_ff     <= pop_entry.neg;
                  mag_ff     <= pop_entry.mag;
                  bit_cnt_ff <= '0;
                  if (pop_entry.hex) begin
                     for (int i = 0; i < DEC_DIGITS; i++) begin
                        digits_ff[i] <= (i < HEX_DIGITS) ?
                                        pop_entry.mag[(i % HEX_DIGITS)*DIGIT_W +: DIGIT_W] :
                                        '0;
                     end
                     cnt_ff   <= CNT_W'(HEX_DIGITS);
                     state_ff <= ST_SKIP;
                  end else begin
                     for (int i = 0; i < DEC_DIGITS; i++) begin
                        digits_ff[i] <= '0;
                     end
                     cnt_ff   <= CNT_W'(DEC_DIGITS);
                     state_ff <= ST_CONV;
                  end
               end
            end
            ST_CONV: begin
               digits_ff  <= dab_in;
               mag_ff     <= {mag_ff[VALUE_W-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + BIT_CNT_W'(1);
               if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
                  state_ff <= ST_SKIP;
               end
            end
            ST_SKIP: begin
               // drop leading zeros, keep at least one digit
               if (cnt_ff > CNT_W'(1) && top_digit == '0) begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end else begin
                  state_ff <= neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
            ST_SIGN: begin
               if (slot_free) begin
                  rsp_data_ff  <= CH_MINUS;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (slot_free) begin
                  rsp_data_ff  <= digit_char(top_digit);
                  rsp_last_ff  <= 1'b0;
                  cnt_ff       <= cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_ff <= ST_NEWLINE;
                  end
               end
            end
            ST_NEWLINE: begin
               if (slot_free) begin
                  rsp_data_ff  <= CH_NEWLINE;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff == CH_NEWLINE))
      else $error("last beat is not a newline");

   a_digit_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_DIGIT) |->
      (cnt_ff != '0 && cnt_ff <= CNT_W'(DEC_DIGITS)))
      else $error("digit count out of range while emitting");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff != ST_IDLE))
      else $error("queue entry popped without starting conversion");

   a_conv_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) |=>
      (state_ff == ST_SKIP))
      else $error("conversion did not end after the last bit");

endmodule

`default_nettype wire

[dv/tb_integer_to_ascii_formatter.sv]
// Self-checking testbench for integer_to_ascii_formatter: decimal and hex text of signed values.
// Scoreboard class predicts the text beats; plain tasks drive req_ and csr_, an initial block stalls rsp_.
// Depends on ita_pkg and the integer_to_ascii_formatter RTL.
`default_nettype none

module tb_integer_to_ascii_formatter;
   timeunit 1ns;
   timeprecision 1ps;

   import ita_pkg::*;

   localparam int GAP_MAX       = 17;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 51;
   localparam int DEC_BASE      = 10;
   localparam int HEX_BASE      = 16;

   typedef struct {
      logic [7:0] text_byte;
      logic       last;
   } text_beat_type;

   class ita_scoreboard_type;
      text_beat_type pending_text[$];
      bit         hex_mode;
      int         failures;
      int         dec_numbers;
      int         hex_numbers;
      int         beats_checked;

      function void set_mode(logic mode);
         hex_mode = mode;
      endfunction

      function int pending();
         return pending_text.size();
      endfunction

      // Expand one accepted value into its sign, digits and newline.
      function void note_value(logic [31:0] raw);
         text_beat_type beat;
         logic       neg;
         logic [31:0] mag;
         int          base;
         logic [3:0]  digs[$];
         logic [7:0]  ch;
         neg  = raw[31];
         mag  = neg ? (~raw + 32'd1) : raw;
         base = hex_mode ? HEX_BASE : DEC_BASE;
         if (hex_mode) hex_numbers++;
         else dec_numbers++;
         do begin
            digs.push_front(4'(mag % base));
            mag = mag / base;
         end while (mag != 0);
         if (neg) begin
            beat.text_byte = CH_MINUS;
            beat.last      = 1'b0;
            pending_text.push_back(beat);
         end
         foreach (digs[i]) begin
            ch = {4'b0000, digs[i]};
            if (digs[i] >= DEC_BASE) ch = ch - 8'(DEC_BASE) + CH_A;
            else ch = ch + CH_ZERO;
            beat.text_byte = ch;
            beat.last      = 1'b0;
            pending_text.push_back(beat);
         end
         beat.text_byte = CH_NEWLINE;
         beat.last      = 1'b1;
         pending_text.push_back(beat);
      endfunction

      function void check_beat(logic [7:0] text_byte, logic last);
         text_beat_type want;
         if (pending_text.size() == 0) begin
            $error("unexpected text beat: text_byte %h last %b", text_byte, last);
            failures++;
            return;
         end
         want = pending_text.pop_front();
         beats_checked++;
         if (text_byte !== want.text_byte) begin
            $error("text_byte expected %h actual %h", want.text_byte, text_byte);
            failures++;
         end
         if (last !== want.last) begin
            $error("last expected %b actual %b", want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata  = '0;

   ita_scoreboard_type text_sb;
   bit  req_steady;
   bit  rsp_steady;
   int  idle_cycles;
   logic moved;

   logic [31:0] corner_values[12] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'd15, 32'd16,
      32'hFFFF_FF01, 32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0FED_CBA9
   };

   integer_to_ascii_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watch every handshake; the scoreboard sees beats in edge order.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_tvalid && csr_tready) begin
            text_sb.set_mode(csr_tdata[0]);
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            text_sb.note_value(req_tdata);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            text_sb.check_beat(rsp_tdata, rsp_tlast);
            moved = 1'b1;
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a beat", idle_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: stall a random number of cycles before each text beat.
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_steady = ~rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_value(input logic [31:0] value);
      int gap;
      if ($urandom_range(0, 15) == 0) req_steady = ~req_steady;
      gap = req_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every predicted beat has come back.
   task automatic drain_text();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (text_sb.pending() != 0);
   endtask

   task automatic write_mode(input logic mode, input logic [6:0] junk);
      csr_tdata  <= {junk, mode};
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) v = $urandom;
      else if (pick == 1) v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else v = $urandom >> $urandom_range(0, 31);
      if (pick != 1 && $urandom_range(0, 1)) v = ~v + 32'd1;
      return v;
   endfunction

   initial begin
      logic first_mode;
      text_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Corner values in both radixes, upper csr bits all ones then all zeros.
      write_mode(1'b0, 7'h7F);
      foreach (corner_values[i]) send_value(corner_values[i]);
      drain_text();
      write_mode(1'b1, 7'h00);
      foreach (corner_values[i]) send_value(corner_values[i]);
      drain_text();

      first_mode = $urandom_range(0, 1);
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_mode(first_mode ^ p[0], 7'($urandom));
         for (int n = 0; n < PHASE_ITEMS; n++) send_value(random_value());
         drain_text();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (text_sb.pending() != 0) begin
         $error("%0d text beats never arrived", text_sb.pending());
         text_sb.failures++;
      end
      $display("formatted %0d values (%0d decimal, %0d hex), %0d text beats checked",
               text_sb.dec_numbers + text_sb.hex_numbers, text_sb.dec_numbers,
               text_sb.hex_numbers, text_sb.beats_checked);
      if (text_sb.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
